// File: hdl/rgb_box_downsample_2x2_core_macros.svh
// ----------------------------------------------------------------------------
// rgb box downsample assertion macros
// concurrent assertion wrappers clocked on i_clk, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_DOWNSAMPLE_2X2_CORE_MACROS_SVH
`define RGB_BOX_DOWNSAMPLE_2X2_CORE_MACROS_SVH

// property checked only while out of reset
`define RGBDS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rgbds assertion failed");

// property checked at every edge, reset included
`define RGBDS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("rgbds assertion failed");

`endif

// File: hdl/rgbds_pkg.sv
// ----------------------------------------------------------------------------
// rgbds_pkg
// shared constants and types of the 2x2 rgb box downsampler
// ----------------------------------------------------------------------------
package rgbds_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int SLOTS      = MAX_WIDTH / 2;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int CH_W       = 8;
    localparam int SUM_W      = CH_W + 1;
    localparam int TOT_W      = SUM_W + 2;
    localparam int LANES      = 3;
    localparam int BUF_W      = LANES * SUM_W;
    localparam int ROUND_ADD  = 3;
    localparam int MEAN_SHIFT = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    // per-lane control from the sequencing logic
    typedef struct packed {
        logic load_held;   // even column: keep the pixel
        logic load_pair;   // odd column, odd row: pair sum into the pair stage
    } t_lane_ctl;

endpackage

// File: hdl/rgb_box_downsample_2x2_core.sv
// ----------------------------------------------------------------------------
// rgb_box_downsample_2x2_core
// 2x2 box filter downsampler for an rgb pixel stream in raster order
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     i_valid / o_stall   i_red_in, i_green_in, i_blue_in
//  output    o_valid / i_stall   o_red_out, o_green_out, o_blue_out,
//                                o_row_end, o_frame_end
//  config    i_cfg_we            i_cfg_idx, i_cfg_data
//
//  one pixel accepted per clock while o_stall is low; the result of the pixel
//  that completes its 2x2 block passes the line buffer read, then the output register
//  synchronous active-low reset clears counters and valid flags and sets the sizes to 640x480;
//  the line buffer is not cleared
//  i_stall holds the output register; the pair stage behind it still takes
//  one more result before o_stall rises
// ----------------------------------------------------------------------------
module rgb_box_downsample_2x2_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rgbds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgbds_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [rgbds_pkg::CH_W-1:0]      i_red_in,
    input  logic [rgbds_pkg::CH_W-1:0]      i_green_in,
    input  logic [rgbds_pkg::CH_W-1:0]      i_blue_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rgbds_pkg::CH_W-1:0]      o_red_out,
    output logic [rgbds_pkg::CH_W-1:0]      o_green_out,
    output logic [rgbds_pkg::CH_W-1:0]      o_blue_out,
    output logic                           o_row_end,
    output logic                           o_frame_end
);
    import rgbds_pkg::*;

    logic [SIZE_W-1:0] r_width, r_height;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [CNT_W-1:0]  r_col, r_row, n_col, n_row;
    logic              acc_in, col_odd, row_odd;
    logic              col_wrap, row_wrap, is_last_col, is_last_row;
    logic [SIZE_W-1:0] last_col, last_row;
    t_lane_ctl         ctl;
    logic              mem_we;
    logic [SLOT_W-1:0] slot;
    logic [BUF_W-1:0]  wdata, rdata;
    logic [CH_W-1:0]   pix  [LANES];
    logic [CH_W-1:0]   mean [LANES];
    logic              r_s1_valid, r_s1_row_end, r_s1_frame_end;
    logic              r_out_valid, r_out_row_end, r_out_frame_end;
    logic [CH_W-1:0]   r_out_ch [LANES];
    logic              s1_ready, out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp sizes into the supported range
    always_comb begin
        priority if (r_width < SIZE_W'(2))               w_eff = SIZE_W'(2);
        else if (r_width > SIZE_W'(MAX_WIDTH))           w_eff = SIZE_W'(MAX_WIDTH);
        else                                              w_eff = r_width;
        priority if (r_height < SIZE_W'(2))              h_eff = SIZE_W'(2);
        else if (r_height > SIZE_W'(MAX_HEIGHT))         h_eff = SIZE_W'(MAX_HEIGHT);
        else                                              h_eff = r_height;
    end

    // handshake
    assign out_ready = !r_out_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_stall   = !s1_ready;
    assign acc_in    = i_valid && s1_ready;

    // position bookkeeping
    assign col_odd     = r_col[0];
    assign row_odd     = r_row[0];
    assign col_wrap    = SIZE_W'(r_col) >= (w_eff - SIZE_W'(1));
    assign row_wrap    = SIZE_W'(r_row) >= (h_eff - SIZE_W'(1));
    assign last_col    = {w_eff[SIZE_W-1:1], 1'b0} - SIZE_W'(1);
    assign last_row    = {h_eff[SIZE_W-1:1], 1'b0} - SIZE_W'(1);
    assign is_last_col = SIZE_W'(r_col) == last_col;
    assign is_last_row = SIZE_W'(r_row) == last_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc_in) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // lane control and line buffer access
    assign ctl.load_held = acc_in && !col_odd;
    assign ctl.load_pair = acc_in && col_odd && row_odd;
    assign mem_we        = acc_in && col_odd && !row_odd;
    assign slot          = r_col[CNT_W-1:1];

    assign pix[0] = i_red_in;
    assign pix[1] = i_green_in;
    assign pix[2] = i_blue_in;

    // one lane per color channel
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        rgbds_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_pix     (pix[k]),
            .i_buf_sum (rdata[k*SUM_W +: SUM_W]),
            .o_pair    (wdata[k*SUM_W +: SUM_W]),
            .o_mean    (mean[k])
        );
    end

    rgbds_linebuf u_linebuf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (slot),
        .i_wdata (wdata),
        .i_re    (ctl.load_pair),
        .i_raddr (slot),
        .o_rdata (rdata)
    );

    // pair stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= ctl.load_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load_pair) begin
            r_s1_row_end   <= is_last_col;
            r_s1_frame_end <= is_last_col && is_last_row;
        end
    end

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out_ch[0]     <= mean[0];
            r_out_ch[1]     <= mean[1];
            r_out_ch[2]     <= mean[2];
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_out_ch[0];
    assign o_green_out = r_out_ch[1];
    assign o_blue_out  = r_out_ch[2];
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule

// File: hdl/rgbds_linebuf.sv
// ----------------------------------------------------------------------------
// rgbds_linebuf
// line buffer of pair sums, one write and one registered read port
// ----------------------------------------------------------------------------
module rgbds_linebuf (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [rgbds_pkg::SLOT_W-1:0] i_waddr,
    input  logic [rgbds_pkg::BUF_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [rgbds_pkg::SLOT_W-1:0] i_raddr,
    output logic [rgbds_pkg::BUF_W-1:0]  o_rdata
);
    import rgbds_pkg::*;

    logic [BUF_W-1:0] r_mem [SLOTS];
    logic [BUF_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rgbds_lane.sv
// ----------------------------------------------------------------------------
// rgbds_lane
// one color channel: pair sum, pair-stage pair register and rounded mean
// ----------------------------------------------------------------------------
module rgbds_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rgbds_pkg::t_lane_ctl        i_ctl,
    input  logic [rgbds_pkg::CH_W-1:0]  i_pix,
    input  logic [rgbds_pkg::SUM_W-1:0] i_buf_sum,
    output logic [rgbds_pkg::SUM_W-1:0] o_pair,
    output logic [rgbds_pkg::CH_W-1:0]  o_mean
);
    import rgbds_pkg::*;

    logic [CH_W-1:0]  r_held;
    logic [SUM_W-1:0] r_pair;
    logic [TOT_W-1:0] total;

    // even-column pixel waiting for its partner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_ctl.load_held) begin
            r_held <= i_pix;
        end
    end

    // horizontal pair sum
    assign o_pair = {1'b0, r_held} + {1'b0, i_pix};

    // pair sum of the odd row, waits for the buffered sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pair) begin
            r_pair <= o_pair;
        end
    end

    // 2x2 sum, rounded up
    assign total  = TOT_W'(r_pair) + TOT_W'(i_buf_sum) + TOT_W'(ROUND_ADD);
    assign o_mean = total[MEAN_SHIFT +: CH_W];

endmodule

// File: hdl/rgbds_checker.sv
// ----------------------------------------------------------------------------
// rgbds_checker
// port-level checks of the downsampler, bound to the top level
// ----------------------------------------------------------------------------
`include "rgb_box_downsample_2x2_core_macros.svh"

module rgbds_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [rgbds_pkg::CH_W-1:0]      o_red_out,
    input logic [rgbds_pkg::CH_W-1:0]      o_green_out,
    input logic [rgbds_pkg::CH_W-1:0]      o_blue_out,
    input logic                           o_row_end,
    input logic                           o_frame_end
);
    // a stalled result transaction stays offered
    `RGBDS_ASSERT(a_valid_hold, o_valid && i_stall |=> o_valid)
    // a stalled result transaction keeps its pixel
    `RGBDS_ASSERT(a_data_hold, o_valid && i_stall |=> $stable({o_red_out, o_green_out, o_blue_out}))
    // the frame ends only on the last pixel of an output row
    `RGBDS_ASSERT(a_frame_row, o_valid && o_frame_end |-> o_row_end)
    // nothing is offered right after reset
    `RGBDS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid)

endmodule

bind rgb_box_downsample_2x2_core rgbds_checker u_rgbds_checker (.*);

// File: verif/tb_rgb_box_downsample_2x2_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_box_downsample_2x2_core
// self-checking bench for the 2x2 rgb box downsampler: a scoreboard class
// predicts every 2x2 mean from the accepted pixel stream and compares it with
// each output transaction, while both channels idle and stall at random and
// the frame size is changed between bursts, mid frame included
// ----------------------------------------------------------------------------
module tb_rgb_box_downsample_2x2_core;
    import rgbds_pkg::*;

    localparam int RANDOM_PIXELS = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    // one downsampled output pixel
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            row_end;
        logic            frame_end;
    } t_box_mean;

    // predicts the 2x2 means and holds them until the block delivers them
    class box_mean_board;
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        logic [BUF_W-1:0]  pair_mem [SLOTS];
        logic [CH_W-1:0]   held_r, held_g, held_b;
        int unsigned       col_idx, row_idx;
        t_box_mean         pending_means[$];
        int                fail_count;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            held_r     = '0;
            held_g     = '0;
            held_b     = '0;
            col_idx    = 0;
            row_idx    = 0;
            fail_count = 0;
            foreach (pair_mem[i]) pair_mem[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
            if (idx == REG_WIDTH) width_reg = data;
            else if (idx == REG_HEIGHT) height_reg = data;
        endfunction

        // sizes outside the supported range saturate
        function int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned top);
            if (v < 2) return 2;
            if (v > top) return top;
            return v;
        endfunction

        function logic [CH_W-1:0] mean4(logic [SUM_W-1:0] a, logic [SUM_W-1:0] c);
            logic [TOT_W-1:0] t;
            t = TOT_W'(a) + TOT_W'(c) + TOT_W'(ROUND_ADD);
            return CH_W'(t >> MEAN_SHIFT);
        endfunction

        function bit on_even_row();
            return (row_idx % 2) == 0;
        endfunction

        function int pending();
            return pending_means.size();
        endfunction

        // note one accepted input pixel
        function void take_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                 logic [CH_W-1:0] b);
            int unsigned      w, h, slot;
            logic [SUM_W-1:0] pr, pg, pb;
            logic [BUF_W-1:0] line;
            t_box_mean        m;
            w = eff_size(width_reg, MAX_WIDTH);
            h = eff_size(height_reg, MAX_HEIGHT);
            if ((col_idx % 2) == 0) begin
                held_r = r;
                held_g = g;
                held_b = b;
            end else begin
                pr   = held_r + r;
                pg   = held_g + g;
                pb   = held_b + b;
                slot = col_idx / 2;
                if (slot < SLOTS) begin
                    if ((row_idx % 2) == 0) begin
                        pair_mem[slot] = {pb, pg, pr};
                    end else begin
                        line        = pair_mem[slot];
                        m.red       = mean4(pr, line[SUM_W-1:0]);
                        m.green     = mean4(pg, line[2*SUM_W-1:SUM_W]);
                        m.blue      = mean4(pb, line[3*SUM_W-1:2*SUM_W]);
                        m.row_end   = (col_idx == 2 * (w / 2) - 1);
                        m.frame_end = m.row_end && (row_idx == 2 * (h / 2) - 1);
                        pending_means.push_back(m);
                    end
                end
            end
            // raster position, wrapping at the current frame size
            if (col_idx >= w - 1) begin
                col_idx = 0;
                row_idx = (row_idx >= h - 1) ? 0 : row_idx + 1;
            end else begin
                col_idx++;
            end
        endfunction

        function string fmt(t_box_mean m);
            return $sformatf("r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b",
                             m.red, m.green, m.blue, m.row_end, m.frame_end);
        endfunction

        // compare one output transaction with the oldest prediction
        function void check_mean(t_box_mean got);
            t_box_mean want;
            if (pending_means.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected output transaction: got %s", fmt(got));
                return;
            end
            want = pending_means.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.row_end !== want.row_end ||
                got.frame_end !== want.frame_end) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("mismatch: expected %s, got %s", fmt(want), fmt(got));
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SIZE_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [CH_W-1:0]      i_red_in, i_green_in, i_blue_in;
    logic                 o_valid;
    logic                 i_stall;
    logic [CH_W-1:0]      o_red_out, o_green_out, o_blue_out;
    logic                 o_row_end, o_frame_end;

    bit tx_quiet;
    bit rx_quiet;

    box_mean_board sb = new();

    rgb_box_downsample_2x2_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned k;
        if (quiet) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // small frame sizes, sometimes below the floor of two
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return SIZE_W'($urandom_range(0, 1));
        if (k < 8) return SIZE_W'($urandom_range(2, 4));
        return SIZE_W'($urandom_range(5, 16));
    endfunction

    // output side back-pressure
    initial begin : rx_pacing
        int unsigned n;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            n = pick_gap(rx_quiet);
            if (n == 0) begin
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // transaction monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.take_pixel(i_red_in, i_green_in, i_blue_in);
            if (o_valid && !i_stall)
                sb.check_mean({o_red_out, o_green_out, o_blue_out, o_row_end, o_frame_end});
        end
    end

    // end the run when nothing moves for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        @(posedge i_clk iff i_rst_n);
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // one input transaction after a random gap
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        int unsigned gap;
        gap = pick_gap(tx_quiet);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    endtask

    // stop the sender and let the pipeline drain
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int sent;
        int len;
        int sel;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_WIDTH;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_red_in   = '0;
        i_green_in = '0;
        i_blue_in  = '0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 2x2 frames: full scale, zero, round-up of a single lsb
        write_size(REG_WIDTH, SIZE_W'(2));
        write_size(REG_HEIGHT, SIZE_W'(2));
        repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);
        repeat (4) send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'd1, 8'd2, 8'd3);
        repeat (3) send_pixel(8'h00, 8'h00, 8'h00);

        // odd width and height: last column and last row are dropped
        settle();
        write_size(REG_WIDTH, SIZE_W'(3));
        write_size(REG_HEIGHT, SIZE_W'(3));
        for (int k = 0; k < 9; k++)
            send_pixel(CH_W'(k * 29 + 7), CH_W'(255 - k * 31), CH_W'(k * 53));

        // sizes below two act as two
        settle();
        write_size(REG_WIDTH, SIZE_W'(1));
        write_size(REG_HEIGHT, SIZE_W'(0));
        send_noise(4);

        // wide and tall frames, in range and saturated, partly filled
        settle();
        write_size(REG_WIDTH, SIZE_W'(MAX_WIDTH));
        write_size(REG_HEIGHT, SIZE_W'(2));
        send_noise(40);
        settle();
        write_size(REG_WIDTH, 11'h7FF);
        send_noise(40);
        settle();
        write_size(REG_WIDTH, SIZE_W'(2));
        write_size(REG_HEIGHT, SIZE_W'(MAX_HEIGHT));
        send_noise(40);
        settle();
        write_size(REG_HEIGHT, 11'h7FF);
        send_noise(40);

        // random bursts with size changes anywhere in the frame;
        // a width change only on an even row, so no unwritten line entry is read
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            settle();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 2);
            if (sel != 1 && sb.on_even_row()) write_size(REG_WIDTH, pick_size());
            if (sel != 0) write_size(REG_HEIGHT, pick_size());
            len = $urandom_range(8, 120);
            send_noise(len);
            sent += len;
        end

        settle();
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
